>>> rtl/core/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  localparam int NUMBER_BITS_DEFAULT = 31;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture candidate, divisor = 3
    logic div_start;  // clear remainder, dividend into quotient register
    logic div_step;   // one restoring division step
    logic inc_d;      // next odd divisor
  } tdpt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_lt2;
    logic n_even;
    logic n_is2;
    logic div_done;   // current step is the last one
    logic d_gt_q;     // divisor exceeds quotient: search is over
    logic rem_zero;
  } tdpt_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate and divisor registers with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_datapath
  import tdpt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [NUMBER_BITS-1:0] candidate,
  input  wire tdpt_cmd_t              cmd,
  output tdpt_status_t                status
);

  localparam int NB = NUMBER_BITS;
  localparam int CW = $clog2(NB);

  logic [NB-1:0] n;
  logic [NB-1:0] d;
  logic [NB-1:0] rem;
  logic [NB-1:0] quo;
  logic [CW-1:0] cnt;

  logic [NB:0]   rem_sh;
  logic [NB:0]   diff;

  assign rem_sh = {rem, quo[NB-1]};
  assign diff   = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= candidate;
      d <= NB'(3);
    end else if (cmd.inc_d) begin
      d <= d + NB'(2);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= n;
    end else if (cmd.div_step) begin
      // quotient bits shift in as dividend bits shift out
      if (!diff[NB]) begin
        rem <= diff[NB-1:0];
        quo <= {quo[NB-2:0], 1'b1};
      end else begin
        rem <= rem_sh[NB-1:0];
        quo <= {quo[NB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    status.n_lt2    = (n[NB-1:1] == '0);
    status.n_even   = !n[0];
    status.n_is2    = (n == NB'(2));
    status.div_done = (cnt == CW'(NB-1));
    status.d_gt_q   = (d > quo);
    status.rem_zero = (rem == '0);
  end

endmodule

`default_nettype wire

>>> rtl/core/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the prime test and owner of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic              result,
  output tdpt_cmd_t         cmd,
  input  wire tdpt_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_CLASSIFY = 5'b00010,
    ST_DIV      = 5'b00100,
    ST_CHECK    = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   verdict, verdict_next;
  logic   out_load;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    state_next    = state;
    verdict_next  = verdict;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.n_lt2) begin
          verdict_next = 1'b0;
          state_next   = ST_FINISH;
        end else if (status.n_even) begin
          verdict_next = status.n_is2;
          state_next   = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // bound test first: divisor past n / divisor means no factor left
        if (status.d_gt_q) begin
          verdict_next = 1'b1;
          state_next   = ST_FINISH;
        end else if (status.rem_zero) begin
          verdict_next = 1'b0;
          state_next   = ST_FINISH;
        end else begin
          cmd.inc_d     = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= verdict;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(result));

  a_div_cmds: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_start && cmd.div_step));

endmodule

`default_nettype wire

>>> rtl/core/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division with odd divisors and a serial divider.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb up)      handshake
//  s_*      in   candidate[NUMBER_BITS-1:0]  s_tvalid / s_tready
//  m_*      out  is_prime[0]                 m_tvalid / m_tready
//
//  Steps: accept, classify, then for each odd divisor tried NUMBER_BITS
//  restoring division steps and one check, then load the result. Even
//  inputs and one skip the division.
//  Reset is synchronous and clears only control state.
//  One word at a time; a new word is taken once the previous result has been
//  loaded into the output register, even while that result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((NUMBER_BITS+7)/8)*8-1:0]  s_tdata,  // candidate
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [7:0]                             m_tdata   // is_prime
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  logic         result;

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result),
    .cmd      (cmd),
    .status   (status)
  );

  tdpt_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .candidate (s_tdata[NUMBER_BITS-1:0]),
    .cmd       (cmd),
    .status    (status)
  );

  assign m_tdata = {7'b0, result};

endmodule

`default_nettype wire

>>> tb/sv/trial_division_prime_test_tb.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// Drives candidates into the trial-division prime tester and checks each
// is_prime verdict against a local trial-division predictor. Directed words
// cover zero, one, two, odd prime squares, the range ends and the ignored top
// bit. Random words follow in three phases of sender/receiver idling, with
// one long receiver hold-off so that the block backs up its input.
// ----------------------------------------------------------------------------

module trial_division_prime_test_tb
  import tdpt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB       = NUMBER_BITS_DEFAULT;
  localparam int TDATA_W  = ((NB + 7) / 8) * 8;
  localparam longint unsigned CAND_MASK = (64'd1 << NB) - 64'd1;
  localparam int WATCHDOG_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {PH_SLOW_RX, PH_SLOW_TX, PH_FLOW} idle_phase_t;

  // --------------------------------------------------------------------------
  class prime_scoreboard;
    typedef struct {
      logic [TDATA_W-1:0] word;
      logic [7:0]         verdict;
    } verdict_t;

    verdict_t verdict_q[$];
    int       mismatches;

    function logic [7:0] predict_verdict(logic [TDATA_W-1:0] word);
      longint unsigned n;
      longint unsigned d;
      n = longint'(word) & CAND_MASK;
      if (n < 2) return 8'd0;
      if (n[0] == 1'b0) return (n == 2) ? 8'd1 : 8'd0;
      for (d = 3; d <= n / d; d += 2) begin
        if (n % d == 0) return 8'd0;
      end
      return 8'd1;
    endfunction

    function void note_candidate(logic [TDATA_W-1:0] word);
      verdict_t v;
      v.word    = word;
      v.verdict = predict_verdict(word);
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic [7:0] got);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %0h", got);
        return;
      end
      v = verdict_q.pop_front();
      if (got !== v.verdict) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: candidate %0h expected %0h got %0h",
                   v.word, v.verdict, got);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;   // candidate
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;         // is_prime

  idle_phase_t     phase = PH_SLOW_RX;
  prime_scoreboard sb    = new();
  int              idle_cycles = 0;

  logic [TDATA_W-1:0] directed_words[$] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0004, 32'd9,         32'd25,        32'd49,
    32'd121,       32'd169,       32'd63001,     32'd15,
    32'd97,        32'd65537,     32'h7FFF_FFFE, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0007, 32'h8000_0009, 32'hFFFF_FFFD,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0002
  };

  trial_division_prime_test #(.NUMBER_BITS(NB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int tx_idle_pct(idle_phase_t p);
    case (p)
      PH_SLOW_RX: return 22;
      PH_SLOW_TX: return 75;
      default:    return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(idle_phase_t p);
    case (p)
      PH_SLOW_RX: return 75;
      PH_SLOW_TX: return 22;
      default:    return 0;
    endcase
  endfunction

  // Keep the search short: big odd words get a small factor built in.
  function automatic logic [TDATA_W-1:0] random_candidate();
    longint unsigned n;
    longint unsigned p;
    longint unsigned a;
    longint unsigned b;
    logic [TDATA_W-1:0] word;
    case ($urandom_range(9))
      0, 1, 2, 3: n = $urandom_range(4095);
      4, 5:       n = {$urandom} & 64'hFFFF_FFFE;
      6, 7: begin
        case ($urandom_range(4))
          0:       p = 3;
          1:       p = 5;
          2:       p = 7;
          3:       p = 11;
          default: p = 13;
        endcase
        n = p * $urandom_range(1, int'(CAND_MASK / p));
      end
      8:          n = $urandom_range(262143);
      default: begin
        a = 2 * $urandom_range(1, 255) + 1;
        b = 2 * $urandom_range(1, 255) + 1;
        n = a * b;
      end
    endcase
    word = TDATA_W'(n & CAND_MASK);
    word[TDATA_W-1] = 1'($urandom_range(1));  // above the candidate, ignored
    return word;
  endfunction

  task automatic send_word(input logic [TDATA_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct(phase)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off when flow phase starts.
  initial begin
    int hold_count;
    bit hold_done;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (phase == PH_FLOW && !hold_done) begin
        m_tready <= 1'b0;
        hold_count++;
        if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct(phase));
      end
    end
  end

  // Check the result before noting a word taken on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_candidate(s_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i]);
    repeat (25) send_word(random_candidate());

    phase <= PH_SLOW_TX;
    repeat (25) send_word(random_candidate());

    // quick words first so the block backs up during the hold-off
    phase <= PH_FLOW;
    repeat (6) send_word(TDATA_W'($urandom_range(255)));
    repeat (21) send_word(random_candidate());

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test.sv
tb/sv/trial_division_prime_test_tb.sv
